FILE: src/sm4_pkg.sv
// sm4 cipher engine package: beat types, register map, mode codes, state codes
// sbox, key-schedule constants and the round helper functions
// no dependencies
package sm4_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int RK_AW       = $clog2(ROUND_COUNT);
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    localparam logic [2:0] REG_KEY_HIGH = 3'd0;
    localparam logic [2:0] REG_KEY_LOW  = 3'd1;
    localparam logic [2:0] REG_IV_HIGH  = 3'd2;
    localparam logic [2:0] REG_IV_LOW   = 3'd3;
    localparam logic [2:0] REG_MODE     = 3'd4;
    localparam logic [2:0] REG_DECRYPT  = 3'd5;

    typedef enum logic [2:0] {
        MODE_ECB = 3'd0,
        MODE_CBC = 3'd1,
        MODE_CFB = 3'd2,
        MODE_OFB = 3'd3,
        MODE_CTR = 3'd4
    } chain_mode_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_KEYEXP = 5'b00010,
        ST_PREP   = 5'b00100,
        ST_ROUND  = 5'b01000,
        ST_DONE   = 5'b10000
    } seq_state_t;

    typedef struct packed {
        logic        message_start;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } sm4_in_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } sm4_out_t;

    typedef struct packed {
        logic key_sched;
    } round_ctrl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] tau(input logic [31:0] x);
        tau = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // key schedule constant, byte j of word i is (4i+j)*7 mod 256
    function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] i);
        logic [7:0]  base;
        logic [31:0] w;
        base = 8'({i, 2'b00});
        w    = '0;
        for (int j = 0; j < 4; j++)
        begin
            w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
        end
        ck_word = w;
    endfunction

endpackage

FILE: src/sm4_block_cipher_modes_core.sv
// sm4 engine with ecb, cbc, cfb, ofb and ctr chaining, apb register port
// a message_start beat runs key expansion before its block; each block then passes prep,
// rounds and done; blk_ready is high only in idle, so one block is in flight; the single
// round unit runs one round per cycle for 32 rounds and 32 key-schedule steps
// reset: rst_n async low clears registers, chaining value and handshakes; round key ram
// holds no reset state and is filled by the first message start
module sm4_block_cipher_modes_core
    import sm4_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              blk_valid,
    output logic              blk_ready,
    input  sm4_in_t           blk,
    output logic              res_valid,
    input  logic              res_ready,
    output sm4_out_t          res
);

    logic [63:0]      key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic [2:0]       mode_reg;
    logic             decrypt_reg;
    seq_state_t       state_reg, state_next;
    logic [RK_AW-1:0] cnt_reg, cnt_next;
    logic             res_valid_reg, res_valid_next;
    logic [127:0]     cv_reg, cv_next;
    logic [127:0]     x_reg, x_next;
    logic [127:0]     blk_reg, blk_next;
    sm4_out_t         res_reg, res_next;

    logic             cfg_we;
    logic [2:0]       reg_idx;
    chain_mode_t      eff_mode;
    logic             reverse;
    logic             accept;
    logic             last;
    logic             done_load;
    logic [127:0]     round_out;
    logic [31:0]      round_word;
    logic [31:0]      rk_rdata;
    logic [31:0]      rkey;
    logic [RK_AW-1:0] rd_cnt;
    logic [RK_AW-1:0] raddr;
    logic             ram_we;
    round_ctrl_t      rctrl;
    logic [127:0]     y;
    logic [127:0]     out_blk;

    // apb register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign cfg_we  = psel & penable & pwrite & pready;

    always_comb
    begin
        case (reg_idx)
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_KEY_LOW:  prdata = key_low_reg;
            REG_IV_HIGH:  prdata = iv_high_reg;
            REG_IV_LOW:   prdata = iv_low_reg;
            REG_MODE:     prdata = {61'd0, mode_reg};
            REG_DECRYPT:  prdata = {63'd0, decrypt_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            mode_reg     <= '0;
            decrypt_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_idx)
                REG_KEY_HIGH: key_high_reg <= pwdata;
                REG_KEY_LOW:  key_low_reg  <= pwdata;
                REG_IV_HIGH:  iv_high_reg  <= pwdata;
                REG_IV_LOW:   iv_low_reg   <= pwdata;
                REG_MODE:     mode_reg     <= pwdata[2:0];
                REG_DECRYPT:  decrypt_reg  <= pwdata[0];
                default:      ;
            endcase
        end
    end

    // mode decode, undefined selectors fall back to ecb
    assign eff_mode = (mode_reg > 3'(MODE_CTR)) ? MODE_ECB : chain_mode_t'(mode_reg);
    assign reverse  = decrypt_reg & ((eff_mode == MODE_ECB) | (eff_mode == MODE_CBC));

    assign blk_ready = (state_reg == ST_IDLE);
    assign accept    = blk_valid & blk_ready;
    assign last      = (cnt_reg == RK_AW'(ROUND_COUNT - 1));
    assign done_load = (state_reg == ST_DONE) & (~res_valid_reg | res_ready);

    // round key store, read in the cycle before the round that uses it
    assign rd_cnt = (state_reg == ST_PREP) ? '0 : cnt_reg + RK_AW'(1);
    assign raddr  = reverse ? ~rd_cnt : rd_cnt;
    assign ram_we = (state_reg == ST_KEYEXP);

    sm4_ram #(
        .WIDTH (32),
        .DEPTH (ROUND_COUNT)
    ) u_rk_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg),
        .wdata (round_word),
        .raddr (raddr),
        .rdata (rk_rdata)
    );

    assign rctrl.key_sched = (state_reg == ST_KEYEXP);
    assign rkey            = rctrl.key_sched ? ck_word(cnt_reg) : rk_rdata;

    sm4_round u_round (
        .state     (x_reg),
        .rkey      (rkey),
        .ctrl      (rctrl),
        .state_out (round_out),
        .word_out  (round_word)
    );

    // cipher output with the final word reversal
    assign y = {x_reg[31:0], x_reg[63:32], x_reg[95:64], x_reg[127:96]};

    always_comb
    begin
        out_blk = y ^ blk_reg;
        cv_next = cv_reg;
        case (eff_mode)
            MODE_CBC:
            begin
                if (decrypt_reg)
                begin
                    out_blk = y ^ cv_reg;
                    cv_next = blk_reg;
                end
                else
                begin
                    out_blk = y;
                    cv_next = y;
                end
            end
            MODE_CFB: cv_next = decrypt_reg ? blk_reg : out_blk;
            MODE_OFB: cv_next = y;
            MODE_CTR: cv_next = cv_reg + 128'd1;
            default:  out_blk = y;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        blk_next       = blk_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg & ~res_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    blk_next = {blk.block_high, blk.block_low};
                    cnt_next = '0;
                    if (blk.message_start)
                    begin
                        x_next     = {key_high_reg[63:32] ^ FK0, key_high_reg[31:0] ^ FK1,
                                      key_low_reg[63:32] ^ FK2, key_low_reg[31:0] ^ FK3};
                        state_next = ST_KEYEXP;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_KEYEXP:
            begin
                x_next   = round_out;
                cnt_next = cnt_reg + RK_AW'(1);
                if (last)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                case (eff_mode)
                    MODE_CBC: x_next = decrypt_reg ? blk_reg : (blk_reg ^ cv_reg);
                    MODE_CFB: x_next = cv_reg;
                    MODE_OFB: x_next = cv_reg;
                    MODE_CTR: x_next = cv_reg;
                    default:  x_next = blk_reg;
                endcase
                cnt_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                x_next   = round_out;
                cnt_next = cnt_reg + RK_AW'(1);
                if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_load)
                begin
                    res_next       = {out_blk[127:64], out_blk[63:0]};
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            cv_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            if (accept & blk.message_start)
            begin
                cv_reg <= {iv_high_reg, iv_low_reg};
            end
            else if (done_load)
            begin
                cv_reg <= cv_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        blk_reg <= blk_next;
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef ASSERT_OFF
    a_start_expands: assert property (@(posedge clk) disable iff (!rst_n)
        (blk_valid && blk_ready && blk.message_start) |=> (state_reg == ST_KEYEXP))
        else $error("message start did not enter key expansion");

    a_plain_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (blk_valid && blk_ready && !blk.message_start) |=> (state_reg == ST_PREP))
        else $error("block without message start skipped prep");

    a_rounds_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |=> (state_reg == ST_ROUND && cnt_reg == '0))
        else $error("cipher rounds did not start at round zero");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside done state");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!res_valid || res_ready))
        |=> (res_valid && state_reg == ST_IDLE))
        else $error("finished block was not moved to the output register");
`endif

endmodule

FILE: src/sm4_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/sm4_round.sv
// shared sm4 round unit: sbox layer plus cipher or key-schedule linear transform
// depends on sm4_pkg
module sm4_round
    import sm4_pkg::*;
(
    input  logic [127:0] state,
    input  logic [31:0]  rkey,
    input  round_ctrl_t  ctrl,
    output logic [127:0] state_out,
    output logic [31:0]  word_out
);

    logic [31:0] t;
    logic [31:0] lin;

    always_comb
    begin
        t = tau(state[95:64] ^ state[63:32] ^ state[31:0] ^ rkey);
        if (ctrl.key_sched)
        begin
            lin = t ^ rotl(t, 13) ^ rotl(t, 23);
        end
        else
        begin
            lin = t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
        end
        word_out  = state[127:96] ^ lin;
        state_out = {state[95:0], word_out};
    end

endmodule

FILE: verif/sm4_block_cipher_modes_core_tb.sv
// testbench for sm4_block_cipher_modes_core: directed and random blocks in all chaining modes,
// apb register setup between messages, random valid/ready gaps and checking against a cipher
// model of its own; depends on sm4_pkg and the core
module sm4_block_cipher_modes_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sm4_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int LONG_HOLD    = 600;
    localparam int TAIL_CYCLES  = 80;
    localparam int REPORT_MAX   = 40;

    localparam logic [2:0] REG_SPARE_A    = 3'd6;
    localparam logic [2:0] REG_SPARE_B    = 3'd7;
    localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;
    localparam logic       DIR_ENC        = 1'b0;
    localparam logic       DIR_DEC        = 1'b1;

    localparam logic [127:0] STD_KEY = 128'h0123456789abcdeffedcba9876543210;
    localparam logic [127:0] STD_CT  = 128'h681edf34d206965e86b3e94f536e4246;

    localparam logic [7:0] SUBST [256] = '{
        'hd6,'h90,'he9,'hfe,'hcc,'he1,'h3d,'hb7,'h16,'hb6,'h14,'hc2,'h28,'hfb,'h2c,'h05,
        'h2b,'h67,'h9a,'h76,'h2a,'hbe,'h04,'hc3,'haa,'h44,'h13,'h26,'h49,'h86,'h06,'h99,
        'h9c,'h42,'h50,'hf4,'h91,'hef,'h98,'h7a,'h33,'h54,'h0b,'h43,'hed,'hcf,'hac,'h62,
        'he4,'hb3,'h1c,'ha9,'hc9,'h08,'he8,'h95,'h80,'hdf,'h94,'hfa,'h75,'h8f,'h3f,'ha6,
        'h47,'h07,'ha7,'hfc,'hf3,'h73,'h17,'hba,'h83,'h59,'h3c,'h19,'he6,'h85,'h4f,'ha8,
        'h68,'h6b,'h81,'hb2,'h71,'h64,'hda,'h8b,'hf8,'heb,'h0f,'h4b,'h70,'h56,'h9d,'h35,
        'h1e,'h24,'h0e,'h5e,'h63,'h58,'hd1,'ha2,'h25,'h22,'h7c,'h3b,'h01,'h21,'h78,'h87,
        'hd4,'h00,'h46,'h57,'h9f,'hd3,'h27,'h52,'h4c,'h36,'h02,'he7,'ha0,'hc4,'hc8,'h9e,
        'hea,'hbf,'h8a,'hd2,'h40,'hc7,'h38,'hb5,'ha3,'hf7,'hf2,'hce,'hf9,'h61,'h15,'ha1,
        'he0,'hae,'h5d,'ha4,'h9b,'h34,'h1a,'h55,'had,'h93,'h32,'h30,'hf5,'h8c,'hb1,'he3,
        'h1d,'hf6,'he2,'h2e,'h82,'h66,'hca,'h60,'hc0,'h29,'h23,'hab,'h0d,'h53,'h4e,'h6f,
        'hd5,'hdb,'h37,'h45,'hde,'hfd,'h8e,'h2f,'h03,'hff,'h6a,'h72,'h6d,'h6c,'h5b,'h51,
        'h8d,'h1b,'haf,'h92,'hbb,'hdd,'hbc,'h7f,'h11,'hd9,'h5c,'h41,'h1f,'h10,'h5a,'hd8,
        'h0a,'hc1,'h31,'h88,'ha5,'hcd,'h7b,'hbd,'h2d,'h74,'hd0,'h12,'hb8,'he5,'hb4,'hb0,
        'h89,'h69,'h97,'h4a,'h0c,'h96,'h77,'h7e,'h65,'hb9,'hf1,'h09,'hc5,'h6e,'hc6,'h84,
        'h18,'hf0,'h7d,'hec,'h3a,'hdc,'h4d,'h20,'h79,'hee,'h5f,'h3e,'hd7,'hcb,'h39,'h48
    };

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_style_t;
    typedef enum int {GAP_NONE, GAP_SHORT, GAP_LONG} gap_style_t;

    class sm4_modes_shadow;
        logic [63:0]  key_hi;
        logic [63:0]  key_lo;
        logic [63:0]  iv_hi;
        logic [63:0]  iv_lo;
        logic [2:0]   mode;
        logic         dec;
        logic [31:0]  rk [ROUND_COUNT];
        logic [127:0] chain;
        sm4_out_t     out_blocks_due [$];
        int           errors;
        int           checked;

        function new();
            key_hi  = '0;
            key_lo  = '0;
            iv_hi   = '0;
            iv_lo   = '0;
            mode    = MODE_ECB;
            dec     = DIR_ENC;
            chain   = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                REG_KEY_HIGH: key_hi = value;
                REG_KEY_LOW:  key_lo = value;
                REG_IV_HIGH:  iv_hi = value;
                REG_IV_LOW:   iv_lo = value;
                REG_MODE:     mode = value[2:0];
                REG_DECRYPT:  dec = value[0];
                default:      ;
            endcase
        endfunction

        function logic [31:0] rol(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function logic [31:0] subst_word(logic [31:0] x);
            return {SUBST[x[31:24]], SUBST[x[23:16]], SUBST[x[15:8]], SUBST[x[7:0]]};
        endfunction

        function void expand_key();
            logic [31:0] k [4];
            logic [31:0] t;
            logic [31:0] ck;
            k[0] = key_hi[63:32] ^ FK0;
            k[1] = key_hi[31:0] ^ FK1;
            k[2] = key_lo[63:32] ^ FK2;
            k[3] = key_lo[31:0] ^ FK3;
            for (int i = 0; i < ROUND_COUNT; i++)
            begin
                ck = '0;
                for (int j = 0; j < 4; j++)
                begin
                    ck = {ck[23:0], 8'((4 * i + j) * 7)};
                end
                t = subst_word(k[1] ^ k[2] ^ k[3] ^ ck);
                t = k[0] ^ t ^ rol(t, 13) ^ rol(t, 23);
                k[0] = k[1];
                k[1] = k[2];
                k[2] = k[3];
                k[3] = t;
                rk[i] = t;
            end
        endfunction

        function logic [127:0] crypt(logic [127:0] din, logic reverse);
            logic [31:0] x [4];
            logic [31:0] t;
            logic [31:0] key;
            x[0] = din[127:96];
            x[1] = din[95:64];
            x[2] = din[63:32];
            x[3] = din[31:0];
            for (int i = 0; i < ROUND_COUNT; i++)
            begin
                key = reverse ? rk[ROUND_COUNT - 1 - i] : rk[i];
                t = subst_word(x[1] ^ x[2] ^ x[3] ^ key);
                t = x[0] ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
                x[0] = x[1];
                x[1] = x[2];
                x[2] = x[3];
                x[3] = t;
            end
            return {x[3], x[2], x[1], x[0]};
        endfunction

        function void take_block(sm4_in_t b);
            logic [127:0] din;
            logic [127:0] ks;
            logic [127:0] o;
            logic [2:0]   m;
            sm4_out_t     r;
            din = {b.block_high, b.block_low};
            m = (mode > MODE_CTR) ? MODE_ECB : mode;
            if (b.message_start)
            begin
                expand_key();
                chain = {iv_hi, iv_lo};
            end
            case (m)
                MODE_CBC:
                begin
                    if (dec)
                    begin
                        o = crypt(din, 1'b1) ^ chain;
                        chain = din;
                    end
                    else
                    begin
                        o = crypt(din ^ chain, 1'b0);
                        chain = o;
                    end
                end
                MODE_CFB:
                begin
                    o = crypt(chain, 1'b0) ^ din;
                    chain = dec ? din : o;
                end
                MODE_OFB:
                begin
                    ks = crypt(chain, 1'b0);
                    o = ks ^ din;
                    chain = ks;
                end
                MODE_CTR:
                begin
                    o = crypt(chain, 1'b0) ^ din;
                    chain = chain + 128'd1;
                end
                default: o = crypt(din, dec);
            endcase
            r.out_high = o[127:64];
            r.out_low  = o[63:0];
            out_blocks_due.push_back(r);
        endfunction

        function void check_block(sm4_out_t got);
            sm4_out_t want;
            checked++;
            if (out_blocks_due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: result beat with none expected, got %h", $time, got);
                return;
            end
            want = out_blocks_due.pop_front();
            if (got.out_high !== want.out_high)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: out_high expected %h got %h", $time, want.out_high,
                             got.out_high);
            end
            if (got.out_low !== want.out_low)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: out_low expected %h got %h", $time, want.out_low,
                             got.out_low);
            end
        endfunction

        function int pending();
            return out_blocks_due.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              blk_valid;
    logic              blk_ready;
    sm4_in_t           blk;
    logic              res_valid;
    logic              res_ready;
    sm4_out_t          res;

    sm4_modes_shadow shadow;
    int              cycle_count;
    int              long_holds_asked = 0;
    int              n_sent = 0;
    int              n_starts = 0;
    int              n_phases = 0;

    sm4_block_cipher_modes_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk       (blk),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            shadow.check_block(res);
    end

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        shadow.write_reg(idx, value);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_block(input logic start, input logic [127:0] data);
        sm4_in_t b;
        b.message_start = start;
        b.block_high    = data[127:64];
        b.block_low     = data[63:0];
        blk       <= b;
        blk_valid <= 1'b1;
        do @(posedge clk); while (!blk_ready);
        shadow.take_block(b);
        n_sent++;
        if (start)
            n_starts++;
    endtask

    task automatic idle_sender(input int cycles);
        blk_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // sender stops until every result beat is back, so the block is idle
    task automatic wait_idle();
        blk_valid <= 1'b0;
        do @(posedge clk); while (shadow.pending() != 0);
    endtask

    task automatic configure(input logic [2:0] m, input logic d, input logic [127:0] iv);
        wait_idle();
        n_phases++;
        write_reg(REG_MODE, 64'(m));
        write_reg(REG_DECRYPT, 64'(d));
        write_reg(REG_IV_HIGH, iv[127:64]);
        write_reg(REG_IV_LOW, iv[63:0]);
        apb_release();
    endtask

    task automatic directed_blocks();
        // registers straight out of reset: zero key, ecb encrypt
        send_block(1'b1, '0);
        wait_idle();
        write_reg(REG_KEY_HIGH, STD_KEY[127:64]);
        write_reg(REG_KEY_LOW, STD_KEY[63:0]);
        apb_release();
        send_block(1'b1, STD_KEY);
        configure(MODE_ECB, DIR_DEC, '0);
        send_block(1'b1, STD_CT);
        for (int m = MODE_CBC; m <= MODE_CTR; m++)
        begin
            for (int d = 0; d < 2; d++)
            begin
                configure(3'(m), 1'(d), {rand64(), rand64()});
                send_block(1'b1, '1);
                send_block(1'b0, {rand64(), rand64()});
            end
        end
        // counter wrap over all 128 bits, then carry from low to high half
        configure(MODE_CTR, DIR_ENC, '1);
        send_block(1'b1, '0);
        send_block(1'b0, '1);
        send_block(1'b0, {rand64(), rand64()});
        configure(MODE_CTR, DIR_DEC, {rand64(), 64'hffff_ffff_ffff_ffff});
        send_block(1'b1, {rand64(), rand64()});
        send_block(1'b0, {rand64(), rand64()});
        // unused mode code runs as ecb
        configure(MODE_SPARE_HI, DIR_DEC, '0);
        send_block(1'b1, {rand64(), rand64()});
        // new key and unused addresses mid-message: key waits for next message start
        wait_idle();
        write_reg(REG_KEY_HIGH, rand64());
        write_reg(REG_KEY_LOW, rand64());
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '1);
        write_reg(REG_MODE, 64'(MODE_CBC));
        write_reg(REG_DECRYPT, 64'(DIR_ENC));
        apb_release();
        send_block(1'b0, {rand64(), rand64()});
    endtask

    task automatic random_config();
        logic [63:0] iv_lo;
        wait_idle();
        n_phases++;
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(REG_KEY_HIGH, rand64());
            write_reg(REG_KEY_LOW, rand64());
        end
        if ($urandom_range(0, 1) == 0)
        begin
            iv_lo = ($urandom_range(0, 2) == 0) ? ~64'($urandom_range(0, 3)) : rand64();
            write_reg(REG_IV_HIGH, rand64());
            write_reg(REG_IV_LOW, iv_lo);
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_MODE, 64'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)));
        else
            write_reg(REG_MODE, 64'($urandom_range(MODE_ECB, MODE_CTR)));
        if ($urandom_range(0, 1) == 0)
            write_reg(REG_DECRYPT, 64'($urandom_range(0, 1) ? DIR_DEC : DIR_ENC));
        if ($urandom_range(0, 19) == 0)
            write_reg(REG_SPARE_A, rand64());
        apb_release();
    endtask

    task automatic random_blocks();
        int         sent;
        int         phase;
        int         len;
        int         burst_left;
        bit         reconfig;
        bit         long_phase;
        logic       start;
        gap_style_t gaps;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase++;
            reconfig   = (phase == 1) || ($urandom_range(0, 1) == 0);
            long_phase = (phase % 97 == 40);
            if (reconfig)
                random_config();
            if (long_phase)
            begin
                len = 24;
                long_holds_asked++;
            end
            else if ($urandom_range(0, 9) < 7)
                len = $urandom_range(1, 8);
            else
                len = $urandom_range(10, 40);
            gaps       = gap_style_t'($urandom_range(GAP_NONE, GAP_LONG));
            burst_left = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
            begin
                if (k == 0)
                    start = reconfig ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 9) == 0);
                else
                    start = ($urandom_range(0, 29) == 0);
                send_block(start, {rand64(), rand64()});
                sent++;
                burst_left--;
                if (burst_left == 0 && k != len - 1 && gaps != GAP_NONE)
                begin
                    idle_sender(gaps == GAP_SHORT ? $urandom_range(1, 5) : $urandom_range(1, 70));
                    burst_left = $urandom_range(1, 8);
                end
            end
            idle_sender($urandom_range(1, 70));
        end
    endtask

    // receiver stall pattern, plus long hold-offs on request
    initial
    begin
        rx_style_t style;
        int        style_left;
        int        hold_left;
        int        holds_seen;
        int        period;
        int        tick;
        style      = RX_ALWAYS;
        style_left = 300;
        hold_left  = 0;
        holds_seen = 0;
        period     = 2;
        tick       = 0;
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (holds_seen != long_holds_asked)
            begin
                holds_seen = long_holds_asked;
                hold_left  = LONG_HOLD;
            end
            if (style_left == 0)
            begin
                style      = rx_style_t'($urandom_range(RX_ALWAYS, RX_PERIODIC));
                style_left = $urandom_range(50, 400);
                period     = $urandom_range(2, 9);
            end
            style_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                case (style)
                    RX_ALWAYS: res_ready <= 1'b1;
                    RX_RANDOM: res_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
                    default:   res_ready <= (tick % period == 0);
                endcase
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 shadow.pending());
        $display("sm4_block_cipher_modes_core_tb NOT OK");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        blk_valid <= 1'b0;
        blk       <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        shadow = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_blocks();
        random_blocks();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("ran %0d blocks (%0d with message start) over %0d register setups", n_sent,
                 n_starts, n_phases);
        $display("checked %0d result beats across ecb, cbc, cfb, ofb, ctr both directions",
                 shadow.checked);
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("sm4_block_cipher_modes_core_tb OK");
        else
            $display("sm4_block_cipher_modes_core_tb NOT OK");
        $finish;
    end

endmodule
